/* sv/mrrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrrc_pkg: shared types and constants for the Modbus RTU reply checker
// Event codes, status codes, register indexes, result word and CRC step.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  // receive buffer limit and derived byte counter width
  localparam int RX_LIMIT = 256;
  localparam int CNT_W    = $clog2(RX_LIMIT + 1);

  // CRC-16/MODBUS, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // shortest frame that can carry address, function and CRC
  localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(4);
  localparam int              HEAD_N    = 3;

  typedef enum logic [2:0] {
    OP_RX_BYTE = 3'd0,
    OP_GAP     = 3'd1,
    OP_TIMEOUT = 3'd2,
    OP_OVERRUN = 3'd3,
    OP_TX_DONE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXC      = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RESEND   = 3'd3,
    ST_LINKFAIL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDR    = 2'd0,
    CFG_EXPECTED_FUNC = 2'd1,
    CFG_MAX_RETRIES   = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_RECV = 1'b1
  } phase_t;

  // one result word
  typedef struct packed {
    status_t          status;
    logic [7:0]       exception_code;
    logic [CNT_W-1:0] byte_count;
    logic             overflow;
    logic [3:0]       retries_used;
  } res_t;

  // one byte through the CRC, bit at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* sv/mrrc_engine.sv */
// ----------------------------------------------------------------------------
// mrrc_engine: reply checker state and result logic
// Holds running CRC, byte count, head bytes, retry count and phase; judges
// the reply on gap, timeout, overrun or buffer limit.
// ----------------------------------------------------------------------------
module mrrc_engine
  import mrrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [2:0] op,
  input  logic [7:0] rx_byte,
  input  logic [7:0] slave_addr,
  input  logic [6:0] expected_func,
  input  logic [3:0] max_retries,
  output logic       res_vld,
  output res_t       res
);

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       head_r   [HEAD_N];
  logic [7:0]       head_nxt [HEAD_N];
  logic [3:0]       retry_r, retry_nxt;
  phase_t           phase_r, phase_nxt;
  logic             ovf_r, ovf_nxt;

  logic    recv;
  logic    room;
  logic    frame_bad;
  logic    retry_left;
  status_t judge_st;
  logic [7:0] judge_exc;

  assign recv       = (phase_r == PH_RECV);
  assign room       = (cnt_r < CNT_W'(RX_LIMIT - 1));
  assign frame_bad  = (head_r[0] != slave_addr) || (cnt_r < MIN_FRAME) || (crc_r != 16'h0000);
  assign retry_left = (retry_r < max_retries);

  // judge the function byte
  always_comb begin
    judge_exc = 8'h00;
    if (head_r[1][7]) begin
      judge_st  = ST_EXC;
      judge_exc = head_r[2];
    end else if (head_r[1] != {1'b0, expected_func}) begin
      judge_st = ST_MISMATCH;
    end else begin
      judge_st = ST_OK;
    end
  end

  // next state
  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    retry_nxt = retry_r;
    phase_nxt = phase_r;
    ovf_nxt   = ovf_r;
    if (fire) begin
      unique case (op)
        OP_TX_DONE: begin
          crc_nxt   = CRC_INIT;
          cnt_nxt   = '0;
          head_nxt  = '{default: 8'h00};
          ovf_nxt   = 1'b0;
          phase_nxt = PH_RECV;
        end
        OP_RX_BYTE: begin
          if (recv) begin
            if (room) begin
              if (cnt_r < CNT_W'(HEAD_N)) head_nxt[cnt_r[1:0]] = rx_byte;
              crc_nxt = crc16_byte(crc_r, rx_byte);
              cnt_nxt = cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt   = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
        end
        OP_OVERRUN: begin
          if (recv) begin
            ovf_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        OP_TIMEOUT: begin
          if (recv) begin
            phase_nxt = PH_IDLE;
            retry_nxt = retry_left ? retry_r + 4'd1 : 4'd0;
          end
        end
        OP_GAP: begin
          if (recv) begin
            phase_nxt = PH_IDLE;
            if (frame_bad) retry_nxt = retry_left ? retry_r + 4'd1 : 4'd0;
            else           retry_nxt = 4'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // result word
  always_comb begin
    res_vld            = 1'b0;
    res.status         = ST_OK;
    res.exception_code = 8'h00;
    res.byte_count     = cnt_r;
    res.overflow       = ovf_nxt;
    res.retries_used   = retry_nxt;
    if (fire && recv) begin
      unique case (op)
        OP_RX_BYTE, OP_OVERRUN: begin
          if (op == OP_OVERRUN || !room) begin
            res_vld            = 1'b1;
            res.status         = judge_st;
            res.exception_code = judge_exc;
          end
        end
        OP_TIMEOUT: begin
          res_vld    = 1'b1;
          res.status = retry_left ? ST_RESEND : ST_LINKFAIL;
        end
        OP_GAP: begin
          res_vld = 1'b1;
          if (frame_bad) begin
            res.status = retry_left ? ST_RESEND : ST_LINKFAIL;
          end else begin
            res.status         = judge_st;
            res.exception_code = judge_exc;
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      cnt_r   <= '0;
      head_r  <= '{default: 8'h00};
      retry_r <= 4'd0;
      phase_r <= PH_IDLE;
      ovf_r   <= 1'b0;
    end else begin
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      retry_r <= retry_nxt;
      phase_r <= phase_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* sv/modbus_rtu_reply_checker_top.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_reply_checker_top: Modbus RTU reply checker, master side
// A result word is registered in the result register when its event word,
// held in the input register, is processed.
// Throughput: one event word per cycle; a result word held by out_stall
// stalls the input, with one event word waiting in the input register.
// Reset (rst_n, synchronous): idle, CRC 0xFFFF, counts cleared, registers
// at slave 1, function 3, three retries.
// ----------------------------------------------------------------------------
module modbus_rtu_reply_checker_top
  import mrrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // event words
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_op,
  input  logic [7:0]       in_rx_byte,
  // result words
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_status,
  output logic [7:0]       out_exception_code,
  output logic [CNT_W-1:0] out_byte_count,
  output logic             out_overflow,
  output logic [3:0]       out_retries_used,
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  logic       in_vld_r;
  logic [2:0] in_op_r;
  logic [7:0] in_byte_r;
  logic [7:0] slave_addr_r;
  logic [6:0] expected_func_r;
  logic [3:0] max_retries_r;
  logic       out_vld_r;
  res_t       out_r;
  logic       fire;
  logic       res_vld;
  res_t       res;

  // handshake: process held word when the result register can take it
  assign fire      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !fire;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op_r   <= in_op;
      in_byte_r <= in_rx_byte;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r    <= 8'd1;
      expected_func_r <= 7'd3;
      max_retries_r   <= 4'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SLAVE_ADDR:    slave_addr_r    <= cfg_data;
        CFG_EXPECTED_FUNC: expected_func_r <= cfg_data[6:0];
        CFG_MAX_RETRIES:   max_retries_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  mrrc_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .op            (in_op_r),
    .rx_byte       (in_byte_r),
    .slave_addr    (slave_addr_r),
    .expected_func (expected_func_r),
    .max_retries   (max_retries_r),
    .res_vld       (res_vld),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) out_r <= res;
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_r.status;
  assign out_exception_code = out_r.exception_code;
  assign out_byte_count     = out_r.byte_count;
  assign out_overflow       = out_r.overflow;
  assign out_retries_used   = out_r.retries_used;

  // exception code only travels with an exception reply
  a_exc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.status != ST_EXC) |-> out_r.exception_code == 8'h00)
    else $error("exception code set on a non-exception result");

  // link failure clears the retry count, a resend leaves it nonzero
  a_retry_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.status == ST_LINKFAIL) |-> out_r.retries_used == 4'd0)
    else $error("link failure with retries left in count");

  a_retry_resend: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_r.status == ST_RESEND) |-> out_r.retries_used != 4'd0)
    else $error("resend without a counted retry");

  // an overflowed frame is judged on its function byte only
  a_ovf_judge: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.overflow |->
      (out_r.status == ST_OK) || (out_r.status == ST_EXC) || (out_r.status == ST_MISMATCH))
    else $error("overflowed frame went through retry path");

endmodule
